@@ design/snapshot_record_deframer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Snapshot record deframer assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define SNAPSHOT_RECORD_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle check, clocked on clk, off while rst_n is low.
`define SRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("srd assertion failed");
// Next-cycle check: cons must hold in the cycle after ante.
`define SRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srd next-cycle assertion failed");
`else
`define SRD_ASSERT(lbl, prop)
`define SRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg
// Types, section codes and record lengths for the snapshot record deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

  typedef logic [7:0] byte_t;

  // Section codes
  localparam logic [2:0] SEC_TYPE       = 3'd0;
  localparam logic [2:0] SEC_HEADER     = 3'd1;
  localparam logic [2:0] SEC_PLAYER     = 3'd2;
  localparam logic [2:0] SEC_MONSTER    = 3'd3;
  localparam logic [2:0] SEC_PROJECTILE = 3'd4;
  localparam logic [2:0] SEC_LOOT       = 3'd5;
  localparam logic [2:0] SEC_SKIP       = 3'd6;

  // Result kinds
  localparam logic [2:0] KIND_HEADER     = 3'd0;
  localparam logic [2:0] KIND_PLAYER     = 3'd1;
  localparam logic [2:0] KIND_MONSTER    = 3'd2;
  localparam logic [2:0] KIND_PROJECTILE = 3'd3;
  localparam logic [2:0] KIND_LOOT       = 3'd4;

  // Lengths in bytes
  localparam logic [4:0] HEADER_LEN     = 5'd9;
  localparam logic [4:0] LEN_PLAYER     = 5'd19;
  localparam logic [4:0] LEN_MONSTER    = 5'd17;
  localparam logic [4:0] LEN_PROJECTILE = 5'd16;
  localparam logic [4:0] LEN_LOOT       = 5'd12;
  localparam int         KEEP_LEN       = 18;
  localparam int         FULL_LEN       = 19;

  typedef logic [KEEP_LEN-1:0][7:0] rec_bytes_t;

  typedef struct packed {
    logic [31:0]        key;
    byte_t              byte_a;
    byte_t              byte_b;
    byte_t              byte_c;
    byte_t              byte_d;
    byte_t              byte_e;
    logic signed [15:0] health;
    logic [31:0]        pos_x_bits;
    logic [31:0]        pos_y_bits;
    logic [15:0]        angle_raw;
    logic [15:0]        speed_raw;
  } srd_result_t;

  typedef struct packed {
    logic [2:0] section;
    byte_t      entries;
  } sec_entry_t;

  // Total length of the header or record gathered under a result kind.
  function automatic logic [4:0] item_len(input logic [2:0] kind);
    logic [4:0] len;
    case (kind)
      KIND_HEADER:     len = HEADER_LEN;
      KIND_PLAYER:     len = LEN_PLAYER;
      KIND_MONSTER:    len = LEN_MONSTER;
      KIND_PROJECTILE: len = LEN_PROJECTILE;
      KIND_LOOT:       len = LEN_LOOT;
      default:         len = HEADER_LEN;
    endcase
    return len;
  endfunction

  // First section at or after start whose count is nonzero; skip if none.
  function automatic sec_entry_t enter_section(input logic [2:0] start,
                                               input byte_t c_player,
                                               input byte_t c_monster,
                                               input byte_t c_proj,
                                               input byte_t c_loot);
    sec_entry_t e;
    if (start <= SEC_PLAYER && c_player != 8'd0) begin
      e = '{SEC_PLAYER, c_player};
    end else if (start <= SEC_MONSTER && c_monster != 8'd0) begin
      e = '{SEC_MONSTER, c_monster};
    end else if (start <= SEC_PROJECTILE && c_proj != 8'd0) begin
      e = '{SEC_PROJECTILE, c_proj};
    end else if (start <= SEC_LOOT && c_loot != 8'd0) begin
      e = '{SEC_LOOT, c_loot};
    end else begin
      e = '{SEC_SKIP, 8'd0};
    end
    return e;
  endfunction

endpackage

@@ design/srd_unpack.sv @@
// ----------------------------------------------------------------------------
// srd_unpack
// Unpacks a complete header or record (stored bytes plus final byte).
// ----------------------------------------------------------------------------
module srd_unpack (
  input  logic [2:0]          kind,
  input  srd_pkg::rec_bytes_t rec,
  input  srd_pkg::byte_t      last_byte,
  output logic                present,
  output srd_pkg::srd_result_t res
);
  import srd_pkg::*;

  logic [FULL_LEN-1:0][7:0] r;
  logic [4:0]               last_idx;

  assign last_idx = item_len(kind) - 5'd1;

  // Final byte goes in place; bytes beyond it are never used.
  always_comb begin
    for (int i = 0; i < FULL_LEN; i++) begin
      if (5'(i) == last_idx) begin
        r[i] = last_byte;
      end else if (i < KEEP_LEN) begin
        r[i] = rec[i];
      end else begin
        r[i] = 8'd0;
      end
    end
  end

  assign present = (r[0] != 8'd0);

  always_comb begin
    res = '0;
    case (kind)
      KIND_HEADER: begin
        res.key    = {r[3], r[2], r[1], r[0]};
        res.byte_a = r[4];
        res.byte_b = r[5];
        res.byte_c = r[6];
        res.byte_d = r[7];
        res.byte_e = r[8];
      end
      KIND_PLAYER: begin
        res.key        = {24'd0, r[1]};
        res.health     = {r[3], r[2]};
        res.pos_x_bits = {r[7], r[6], r[5], r[4]};
        res.pos_y_bits = {r[11], r[10], r[9], r[8]};
        res.angle_raw  = {r[13], r[12]};
        res.byte_a     = r[14];
        res.byte_b     = {7'd0, (r[15] != 8'd0)};
        res.byte_c     = r[16];
        res.byte_d     = r[17];
        res.byte_e     = r[18];
      end
      KIND_MONSTER: begin
        res.key        = {24'd0, r[1]};
        res.byte_a     = r[2];
        res.byte_b     = r[3];
        res.health     = {r[5], r[4]};
        res.pos_x_bits = {r[9], r[8], r[7], r[6]};
        res.pos_y_bits = {r[13], r[12], r[11], r[10]};
        res.angle_raw  = {r[15], r[14]};
        res.byte_c     = r[16];
      end
      KIND_PROJECTILE: begin
        res.key        = {24'd0, r[1]};
        res.byte_a     = r[2];
        res.byte_b     = r[3];
        res.pos_x_bits = {r[7], r[6], r[5], r[4]};
        res.pos_y_bits = {r[11], r[10], r[9], r[8]};
        res.angle_raw  = {r[13], r[12]};
        res.speed_raw  = {r[15], r[14]};
      end
      KIND_LOOT: begin
        res.key        = {24'd0, r[1]};
        res.byte_a     = r[2];
        res.byte_b     = r[3];
        res.pos_x_bits = {r[7], r[6], r[5], r[4]};
        res.pos_y_bits = {r[11], r[10], r[9], r[8]};
      end
      default: res = '0;
    endcase
  end

endmodule

@@ design/snapshot_record_deframer_core.sv @@
// ----------------------------------------------------------------------------
// snapshot_record_deframer_core
// Byte-stream deframer for snapshot packets: header plus four record sections.
// ----------------------------------------------------------------------------
// Takes one packet byte per item (in_tlast on the final byte) and turns each
// snapshot packet into result items: one for the 9-byte header, then one per
// complete player/monster/projectile/loot record whose present byte is
// nonzero. A packet whose first byte differs from cfg_wdata as last written
// (reset 0) is dropped up to its last byte. A record cut short by the end
// of the packet is dropped, and so is everything after it. Rate: one byte
// item per clock while out_tready is high; a result appears on out_* in
// the cycle after the byte that completes it, held in the single output
// register. in_tready drops only while that register is full and not taken.
// ----------------------------------------------------------------------------
`include "snapshot_record_deframer_core_defines.svh"

module snapshot_record_deframer_core (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: snapshot_type
  input  logic         cfg_wen,
  input  logic [7:0]   cfg_wdata,
  // input bytes
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] packet_byte
  input  logic         in_tlast,   // end_of_packet
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata,  // key, byte_a..byte_e, health, pos_x_bits,
                                   // pos_y_bits, angle_raw, speed_raw (low first)
  output logic [2:0]   out_tuser   // [2:0] record_kind
);
  import srd_pkg::*;

  // Configuration
  byte_t snapshot_type_r;

  // Parse state
  logic [2:0] section_r, section_nxt;
  logic [4:0] pos_r, pos_nxt;      // bytes taken of current header/record
  byte_t      entries_r, entries_nxt;
  logic [2:0][7:0] later_counts_r, later_counts_nxt; // monster, projectile, loot
  rec_bytes_t rec_r;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  srd_result_t out_res_r;

  logic        accept;
  logic        store_en;
  logic        emit;
  logic [2:0]  kind;
  logic [4:0]  last_pos;
  logic        present;
  srd_result_t res;
  sec_entry_t  entry;
  byte_t       dec_entries;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Result kind follows the section code by one.
  assign kind     = section_r - 3'd1;
  assign last_pos = item_len(kind) - 5'd1;

  srd_unpack u_unpack (
    .kind      (kind),
    .rec       (rec_r),
    .last_byte (in_tdata),
    .present   (present),
    .res       (res)
  );

  always_comb begin
    section_nxt      = section_r;
    pos_nxt          = pos_r;
    entries_nxt      = entries_r;
    later_counts_nxt = later_counts_r;
    store_en         = 1'b0;
    emit             = 1'b0;
    dec_entries      = entries_r - 8'd1;
    entry            = enter_section(SEC_PLAYER, rec_r[5], rec_r[6], rec_r[7], in_tdata);

    case (section_r)
      SEC_TYPE: begin
        section_nxt = (in_tdata == snapshot_type_r) ? SEC_HEADER : SEC_SKIP;
        pos_nxt     = 5'd0;
      end
      SEC_HEADER: begin
        if (pos_r < last_pos) begin
          store_en = 1'b1;
          pos_nxt  = pos_r + 5'd1;
        end else begin
          emit             = 1'b1;
          later_counts_nxt = {in_tdata, rec_r[7], rec_r[6]};
          section_nxt      = entry.section;
          entries_nxt      = entry.entries;
          pos_nxt          = 5'd0;
        end
      end
      SEC_PLAYER, SEC_MONSTER, SEC_PROJECTILE, SEC_LOOT: begin
        if (pos_r < last_pos) begin
          store_en = 1'b1;
          pos_nxt  = pos_r + 5'd1;
        end else begin
          emit        = present;
          pos_nxt     = 5'd0;
          entries_nxt = dec_entries;
          if (dec_entries == 8'd0) begin
            entry = enter_section(section_r + 3'd1, 8'd0, later_counts_r[0],
                                  later_counts_r[1], later_counts_r[2]);
            section_nxt = entry.section;
            entries_nxt = entry.entries;
          end
        end
      end
      default: begin
        // skip: wait for end of packet
      end
    endcase

    if (in_tlast) begin
      section_nxt = SEC_TYPE;
      pos_nxt     = 5'd0;
      entries_nxt = 8'd0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snapshot_type_r <= 8'd0;
      section_r       <= SEC_TYPE;
      pos_r           <= 5'd0;
      entries_r       <= 8'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        snapshot_type_r <= cfg_wdata;
      end
      if (accept) begin
        section_r <= section_nxt;
        pos_r     <= pos_nxt;
        entries_r <= entries_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: byte store, later counts, result
  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      rec_r[pos_r] <= in_tdata;
    end
    if (accept) begin
      later_counts_r <= later_counts_nxt;
    end
    if (accept && emit) begin
      out_kind_r <= kind;
      out_res_r  <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_res_r.speed_raw, out_res_r.angle_raw,
                       out_res_r.pos_y_bits, out_res_r.pos_x_bits,
                       out_res_r.health, out_res_r.byte_e, out_res_r.byte_d,
                       out_res_r.byte_c, out_res_r.byte_b, out_res_r.byte_a,
                       out_res_r.key};

  // Assertions
  `SRD_ASSERT(a_pos_in_record, pos_r < 5'(FULL_LEN))
  `SRD_ASSERT(a_header_pos, section_r != SEC_HEADER || pos_r < HEADER_LEN)
  `SRD_ASSERT(a_records_due, section_r < SEC_PLAYER || section_r > SEC_LOOT || entries_r != 8'd0)
  `SRD_ASSERT_NEXT(a_eop_restart, accept && in_tlast, section_r == SEC_TYPE && pos_r == 5'd0)
  `SRD_ASSERT_NEXT(a_stall_holds_kind, out_valid_r && !out_tready, out_valid_r && $stable(out_kind_r))

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for snapshot_record_deframer_core.
// ----------------------------------------------------------------------------
// A short table of hand-built packets comes first. It covers a wrong type
// byte, a packet cut off inside the header, a header with all counts zero,
// trailing bytes, and a loot record cut off by the end of the packet. The
// header items in that table carry their expected result. After that come
// random snapshot packets under several snapshot_type settings: mostly
// well-formed, with random contents. Some have a wrong type byte, some are
// truncated, some have trailing bytes, and a few have huge record counts
// and are cut short. An in-bench deframer predicts each result item, and
// every result leaving the block is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import srd_pkg::*;

  // Expected or observed result item: kind plus unpacked fields.
  typedef struct {
    logic [2:0]  kind;
    srd_result_t f;
  } snap_item_t;

  // One row of the directed packet table.
  typedef struct {
    byte_t       data;
    bit          last;
    bit          typed;  // expected result typed in below
    logic [2:0]  kind;
    logic [31:0] key;
    byte_t       a, b, c, d, e;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Directed packets. Type byte 0 matches the reset value of snapshot_type.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // wrong type byte: ignored
    '{8'h55, 1'b1, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // packet ends inside the header: no result
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b1, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // max tick, max recipient, all sections empty, one trailing byte
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b1, KIND_HEADER, 32'hFFFF_FFFF,
      8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hAA, 1'b1, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // tick with MSB and LSB set, one loot record cut after its present byte
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7E, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, 1'b1, KIND_HEADER, 32'h8000_0001,
      8'h7E, 8'h00, 8'h00, 8'h00, 8'h01},
    '{8'h01, 1'b1, 1'b0, KIND_HEADER, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic         clk;
  logic         rst_n;
  logic         cfg_wen;
  logic [7:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;    // [7:0] packet_byte
  logic         in_tlast;    // end_of_packet
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;   // key, byte_a..byte_e, health, pos_x_bits,
                             // pos_y_bits, angle_raw, speed_raw (low first)
  logic [2:0]   out_tuser;   // [2:0] record_kind

  snapshot_record_deframer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the deframer's section walk
  // --------------------------------------------------------------------------
  byte_t      want_type;      // snapshot_type as last written
  logic [2:0] cur_section;
  logic [4:0] cur_pos;        // bytes taken of current header or record
  byte_t      cur_left;       // records still due in current section
  byte_t      later_cnt [3];  // monster, projectile, loot counts
  byte_t      gather [19];    // bytes of header/record being gathered

  snap_item_t pending_results [$];  // predicted result items, oldest first

  int errors;
  int bytes_sent;
  int packets_sent;
  int type_settings;
  int results_seen;
  int kind_tally [5];
  int burst_left;

  function automatic logic [15:0] gather16(input int i);
    return {gather[i+1], gather[i]};
  endfunction

  function automatic logic [31:0] gather32(input int i);
    return {gather[i+3], gather[i+2], gather[i+1], gather[i]};
  endfunction

  // Move to section start, or the first later one with a nonzero count.
  function automatic void open_section(input int start, input byte_t first);
    byte_t cnt;
    cnt = first;
    cur_section = SEC_SKIP;
    cur_left = 8'd0;
    cur_pos = 5'd0;
    for (int s = start; s <= int'(SEC_LOOT); s++) begin
      if (s > int'(SEC_PLAYER)) cnt = later_cnt[s - int'(SEC_MONSTER)];
      if (cnt != 8'd0) begin
        cur_section = 3'(s);
        cur_left = cnt;
        return;
      end
    end
  endfunction

  // Take one packet byte; returns 1 with the result item when one is due.
  function automatic bit deframe_byte(input byte_t din, input bit eop,
                                      output snap_item_t res);
    bit         hit;
    logic [2:0] kind;
    logic [4:0] len;
    hit = 1'b0;
    res.kind = KIND_HEADER;
    res.f = '0;
    kind = KIND_LOOT;
    len = LEN_LOOT;
    case (cur_section)
      SEC_PLAYER:     begin kind = KIND_PLAYER;     len = LEN_PLAYER;     end
      SEC_MONSTER:    begin kind = KIND_MONSTER;    len = LEN_MONSTER;    end
      SEC_PROJECTILE: begin kind = KIND_PROJECTILE; len = LEN_PROJECTILE; end
      default:        ;
    endcase

    if (cur_section == SEC_TYPE) begin
      cur_section = (din == want_type) ? SEC_HEADER : SEC_SKIP;
      cur_pos = 5'd0;
    end else if (cur_section == SEC_HEADER) begin
      if (cur_pos < HEADER_LEN - 5'd1) begin
        gather[cur_pos] = din;
        cur_pos++;
      end else begin
        hit = 1'b1;
        res.f.key = gather32(0);
        res.f.byte_a = gather[4];
        res.f.byte_b = gather[5];
        res.f.byte_c = gather[6];
        res.f.byte_d = gather[7];
        res.f.byte_e = din;
        later_cnt[0] = gather[6];
        later_cnt[1] = gather[7];
        later_cnt[2] = din;
        open_section(int'(SEC_PLAYER), gather[5]);
      end
    end else if (cur_section >= SEC_PLAYER && cur_section <= SEC_LOOT) begin
      if (cur_pos < len - 5'd1) begin
        gather[cur_pos] = din;
        cur_pos++;
      end else begin
        gather[len - 5'd1] = din;
        if (gather[0] != 8'd0) begin
          hit = 1'b1;
          res.kind = kind;
          res.f.key = {24'd0, gather[1]};
          case (kind)
            KIND_PLAYER: begin
              res.f.health = gather16(2);
              res.f.pos_x_bits = gather32(4);
              res.f.pos_y_bits = gather32(8);
              res.f.angle_raw = gather16(12);
              res.f.byte_a = gather[14];
              res.f.byte_b = (gather[15] != 8'd0) ? 8'd1 : 8'd0;
              res.f.byte_c = gather[16];
              res.f.byte_d = gather[17];
              res.f.byte_e = gather[18];
            end
            KIND_MONSTER: begin
              res.f.byte_a = gather[2];
              res.f.byte_b = gather[3];
              res.f.health = gather16(4);
              res.f.pos_x_bits = gather32(6);
              res.f.pos_y_bits = gather32(10);
              res.f.angle_raw = gather16(14);
              res.f.byte_c = gather[16];
            end
            default: begin
              // projectile and loot share the front layout
              res.f.byte_a = gather[2];
              res.f.byte_b = gather[3];
              res.f.pos_x_bits = gather32(4);
              res.f.pos_y_bits = gather32(8);
              if (kind == KIND_PROJECTILE) begin
                res.f.angle_raw = gather16(12);
                res.f.speed_raw = gather16(14);
              end
            end
          endcase
        end
        cur_pos = 5'd0;
        cur_left--;
        if (cur_left == 8'd0) open_section(int'(cur_section) + 1, 8'd0);
      end
    end

    // end of packet always returns to waiting for a type byte
    if (eop) begin
      cur_section = SEC_TYPE;
      cur_pos = 5'd0;
      cur_left = 8'd0;
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, timeout
  // --------------------------------------------------------------------------
  always #4 clk = ~clk;

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  // Called and returns at a falling edge; in_tvalid stays high between items
  // of one burst, so it is never lowered and raised in the same step.
  task automatic send_byte(input byte_t din, input bit eop, input bit typed,
                           input snap_item_t typed_item);
    snap_item_t got;
    bit         hit;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= din;
    in_tlast  <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hit = deframe_byte(din, eop, got);
    if (typed) pending_results = {pending_results, typed_item};
    else if (hit) pending_results = {pending_results, got};
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Idle the sender, let the block drain, then write snapshot_type.
  task automatic write_snapshot_type(input byte_t value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);  // drain margin
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    want_type = value;
    type_settings++;
  endtask

  // Build one random snapshot packet and send it.
  task automatic send_snapshot();
    byte_t       pkt [$];
    byte_t       cnt [4];
    logic [31:0] tick;
    bit          huge;
    int          len;
    int          lim;
    snap_item_t  unused;
    unused.kind = KIND_HEADER;
    unused.f = '0;

    // mostly the configured type; sometimes noise
    pkt = {pkt, (($urandom_range(0, 9) == 0) ? byte_t'($urandom) : want_type)};
    case ($urandom_range(0, 5))
      0:       tick = 32'h0;
      1:       tick = 32'hFFFF_FFFF;
      default: tick = $urandom;
    endcase
    for (int i = 0; i < 4; i++) pkt = {pkt, tick[8*i +: 8]};
    pkt = {pkt, byte_t'($urandom)};  // recipient

    // huge counts are always truncated well before their end
    huge = ($urandom_range(0, 24) == 0);
    for (int i = 0; i < 4; i++) begin
      cnt[i] = huge ? byte_t'($urandom) : byte_t'($urandom_range(0, 3));
      pkt = {pkt, cnt[i]};
    end

    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       len = LEN_PLAYER;
        1:       len = LEN_MONSTER;
        2:       len = LEN_PROJECTILE;
        default: len = LEN_LOOT;
      endcase
      for (int r = 0; r < int'(cnt[s]) && pkt.size() < 100; r++) begin
        // present byte zero about one record in five
        pkt = {pkt, (($urandom_range(0, 4) == 0) ? 8'h00
                                                 : byte_t'($urandom_range(1, 255)))};
        for (int j = 1; j < len; j++)
          pkt = {pkt, (($urandom_range(0, 7) == 0) ? 8'h00 : byte_t'($urandom))};
      end
    end

    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) pkt = {pkt, byte_t'($urandom)};

    len = pkt.size();
    if (huge || $urandom_range(0, 6) == 0) begin
      lim = pkt.size() - 1;
      if (lim > 60) lim = 60;
      len = $urandom_range(1, lim);
    end

    for (int i = 0; i < len; i++) send_byte(pkt[i], (i == len - 1), 1'b0, unused);
    packets_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in four modes, switched at random cycles
  // --------------------------------------------------------------------------
  initial begin : rx_stall
    int mode;
    int mode_left;
    int cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      cyc++;
      case (mode)
        0:       out_tready <= 1'b1;                          // no stalls
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 4) == 0);   // heavy back-pressure
        default: out_tready <= ((cyc % 7) > 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  snap_item_t seen_item;
  snap_item_t want_item;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_item.kind         = out_tuser;
      seen_item.f.key        = out_tdata[31:0];
      seen_item.f.byte_a     = out_tdata[39:32];
      seen_item.f.byte_b     = out_tdata[47:40];
      seen_item.f.byte_c     = out_tdata[55:48];
      seen_item.f.byte_d     = out_tdata[63:56];
      seen_item.f.byte_e     = out_tdata[71:64];
      seen_item.f.health     = out_tdata[87:72];
      seen_item.f.pos_x_bits = out_tdata[119:88];
      seen_item.f.pos_y_bits = out_tdata[151:120];
      seen_item.f.angle_raw  = out_tdata[167:152];
      seen_item.f.speed_raw  = out_tdata[183:168];
      results_seen++;
      if (seen_item.kind <= KIND_LOOT) kind_tally[seen_item.kind]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result item, kind %0d", out_tuser);
        errors++;
      end else begin
        want_item = pending_results.pop_front();
        compare_field("record_kind", 32'(want_item.kind), 32'(seen_item.kind));
        compare_field("key", want_item.f.key, seen_item.f.key);
        compare_field("byte_a", 32'(want_item.f.byte_a), 32'(seen_item.f.byte_a));
        compare_field("byte_b", 32'(want_item.f.byte_b), 32'(seen_item.f.byte_b));
        compare_field("byte_c", 32'(want_item.f.byte_c), 32'(seen_item.f.byte_c));
        compare_field("byte_d", 32'(want_item.f.byte_d), 32'(seen_item.f.byte_d));
        compare_field("byte_e", 32'(want_item.f.byte_e), 32'(seen_item.f.byte_e));
        compare_field("health", {16'd0, want_item.f.health},
                      {16'd0, seen_item.f.health});
        compare_field("pos_x_bits", want_item.f.pos_x_bits, seen_item.f.pos_x_bits);
        compare_field("pos_y_bits", want_item.f.pos_y_bits, seen_item.f.pos_y_bits);
        compare_field("angle_raw", 32'(want_item.f.angle_raw),
                      32'(seen_item.f.angle_raw));
        compare_field("speed_raw", 32'(want_item.f.speed_raw),
                      32'(seen_item.f.speed_raw));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    snap_item_t typed_item;
    int         phase_start;
    byte_t      phase_types [3];
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = 8'h00;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;

    // predictor reset state
    want_type = 8'h00;
    cur_section = SEC_TYPE;
    cur_pos = 5'd0;
    cur_left = 8'd0;
    foreach (later_cnt[i]) later_cnt[i] = 8'h00;
    foreach (gather[i]) gather[i] = 8'h00;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    errors = 0;
    bytes_sent = 0;
    packets_sent = 0;
    type_settings = 1;  // reset value
    results_seen = 0;
    burst_left = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table, under the reset snapshot_type of zero
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_item.kind         = dir_rows[i].kind;
      typed_item.f            = '0;
      typed_item.f.key        = dir_rows[i].key;
      typed_item.f.byte_a     = dir_rows[i].a;
      typed_item.f.byte_b     = dir_rows[i].b;
      typed_item.f.byte_c     = dir_rows[i].c;
      typed_item.f.byte_d     = dir_rows[i].d;
      typed_item.f.byte_e     = dir_rows[i].e;
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, typed_item);
      if (dir_rows[i].last) packets_sent++;
    end

    // random packets: top type value, a random one, then back to zero
    phase_types[0] = 8'hFF;
    phase_types[1] = byte_t'($urandom_range(1, 254));
    phase_types[2] = 8'h00;
    for (int p = 0; p < 3; p++) begin
      write_snapshot_type(phase_types[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 600) send_snapshot();
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d packets, %0d bytes, %0d snapshot_type settings",
             packets_sent, bytes_sent, type_settings);
    $display("checked %0d results: %0d header %0d player %0d monster %0d proj %0d loot",
             results_seen, kind_tally[0], kind_tally[1], kind_tally[2],
             kind_tally[3], kind_tally[4]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
